@@ hdl/swhsr_pkg.sv @@
// ----------------------------------------------------------------------------
// swhsr_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int CNT_W_DEFAULT = 16;
  localparam int CFG_W         = 16;
  localparam int WAIT_W        = 8;
  localparam int DATA_W        = 16;
  localparam int FRAME_BITS    = 40;
  localparam int BIT_IDX_W     = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int STATUS_W      = 2;

  localparam logic [CFG_W-1:0]  RST_START_LOW    = 16'd1100;
  localparam logic [WAIT_W-1:0] RST_RELEASE_WAIT = 8'd55;
  localparam logic [CFG_W-1:0]  RST_TIMEOUT      = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_LOW,
    PH_WAIT,
    PH_RESP_LOW,
    PH_RESP_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_t;

  typedef struct packed {
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic [STATUS_W-1:0]      status;
    logic [DATA_W-1:0]        humidity_tenths;
    logic signed [DATA_W-1:0] temperature_tenths;
  } res_t;

endpackage

@@ hdl/swhsr_core.sv @@
// ----------------------------------------------------------------------------
// swhsr_core
// Protocol sequencer, pulse timers, frame shift register and result decode.
// State advances by one tick for each accepted line sample.
// ----------------------------------------------------------------------------
module swhsr_core import swhsr_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_W_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_en,
  input  logic                 start_req,
  input  logic                 line_level,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output res_t                 res
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] CMAX = '1;
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] ZERO = '0;

  logic [CFG_W-1:0]  start_low_ticks;
  logic [WAIT_W-1:0] release_wait_ticks;
  logic [CFG_W-1:0]  timeout_ticks;

  phase_t                phase, phase_next;
  logic [CW-1:0]         tick_count, tick_count_next;
  logic [CW-1:0]         low_length, low_length_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [DATA_W-1:0]     last_humidity, last_humidity_next;
  logic [DATA_W-1:0]     last_temperature, last_temperature_next;
  logic [STATUS_W-1:0]   last_status, last_status_next;

  logic                  measuring, want_high, level_match;
  logic [CW-1:0]         tick_inc, meas_tick;
  logic                  start_done, wait_done, bit_val, frame_end, timeout_hit;
  logic [BIT_IDX_W-1:0]  index_inc;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [7:0]            b0, b1, b2, b3, b4, byte_sum;
  logic [14:0]           magnitude;
  logic [DATA_W-1:0]     temp_value;
  logic                  done;

  // Shared timing and frame terms.
  always_comb begin
    measuring   = phase inside {PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH};
    want_high   = phase inside {PH_RESP_HIGH, PH_BIT_HIGH};
    level_match = (line_level == want_high);
    tick_inc    = (tick_count == CMAX) ? tick_count : tick_count + ONE;
    meas_tick   = level_match ? tick_inc : ONE;
    start_done  = (CMPW'(tick_count) >= CMPW'(start_low_ticks)) || (tick_count == CMAX);
    wait_done   = (CMPW'(tick_count) >= CMPW'(release_wait_ticks)) ||
                  (tick_count == CMAX);
    bit_val     = tick_count > low_length;
    frame_shift = {frame_bits[FRAME_BITS-2:0], bit_val};
    index_inc   = bit_index + BIT_IDX_W'(1);
    frame_end   = (phase == PH_BIT_HIGH) && !level_match &&
                  (index_inc >= BIT_IDX_W'(FRAME_BITS));
    // The pulse that closes the frame is not checked against the timeout.
    timeout_hit = measuring && !frame_end &&
                  ((CMPW'(meas_tick) >= CMPW'(timeout_ticks)) || (meas_tick == CMAX));
    b0          = frame_shift[39:32];
    b1          = frame_shift[31:24];
    b2          = frame_shift[23:16];
    b3          = frame_shift[15:8];
    b4          = frame_shift[7:0];
    byte_sum    = b0 + b1 + b2 + b3;
    magnitude   = {b2[6:0], b3};
    temp_value  = b2[7] ? (DATA_W'(0) - {1'b0, magnitude}) : {1'b0, magnitude};
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:      if (start_req) phase_next = PH_START_LOW;
      PH_START_LOW: if (start_done) phase_next = PH_WAIT;
      PH_WAIT:      if (wait_done) phase_next = PH_RESP_LOW;
      PH_RESP_LOW:  if (!level_match) phase_next = PH_RESP_HIGH;
      PH_RESP_HIGH: if (!level_match) phase_next = PH_BIT_LOW;
      PH_BIT_LOW:   if (!level_match) phase_next = PH_BIT_HIGH;
      PH_BIT_HIGH:  if (!level_match) phase_next = frame_end ? PH_IDLE : PH_BIT_LOW;
      default:      phase_next = PH_IDLE;
    endcase
    if (timeout_hit) phase_next = PH_IDLE;
  end

  // Datapath updates and the result of this tick.
  always_comb begin
    tick_count_next       = tick_count;
    low_length_next       = low_length;
    bit_index_next        = bit_index;
    frame_bits_next       = frame_bits;
    last_humidity_next    = last_humidity;
    last_temperature_next = last_temperature;
    last_status_next      = last_status;
    case (phase)
      PH_IDLE: begin
        if (start_req) tick_count_next = ONE;
      end
      PH_START_LOW: begin
        tick_count_next = start_done ? ZERO : tick_inc;
      end
      PH_WAIT: begin
        tick_count_next = wait_done ? ZERO : tick_inc;
      end
      PH_RESP_LOW: begin
        tick_count_next = meas_tick;
      end
      PH_RESP_HIGH: begin
        tick_count_next = meas_tick;
        if (!level_match) begin
          bit_index_next  = '0;
          frame_bits_next = '0;
        end
      end
      PH_BIT_LOW: begin
        tick_count_next = meas_tick;
        if (!level_match) low_length_next = tick_count;
      end
      PH_BIT_HIGH: begin
        tick_count_next = meas_tick;
        if (!level_match) begin
          frame_bits_next = frame_shift;
          bit_index_next  = index_inc;
        end
        if (frame_end) begin
          if (byte_sum == b4) begin
            last_humidity_next    = {b0, b1};
            last_temperature_next = temp_value;
            last_status_next      = ST_OK;
          end else begin
            last_status_next = ST_CHECKSUM;
          end
        end
      end
      default: ;
    endcase
    if (timeout_hit) last_status_next = ST_TIMEOUT;
    done = frame_end || timeout_hit;

    res.drive_low          = (phase_next == PH_START_LOW);
    res.busy_res           = (phase_next != PH_IDLE);
    res.done_res           = done;
    res.status             = last_status_next;
    res.humidity_tenths    = last_humidity_next;
    res.temperature_tenths = last_temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks    <= RST_START_LOW;
      release_wait_ticks <= RST_RELEASE_WAIT;
      timeout_ticks      <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_LOW:    start_low_ticks    <= cfg_data;
        CFG_RELEASE_WAIT: release_wait_ticks <= cfg_data[WAIT_W-1:0];
        CFG_TIMEOUT:      timeout_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      low_length       <= '0;
      bit_index        <= '0;
      frame_bits       <= '0;
      last_humidity    <= '0;
      last_temperature <= '0;
      last_status      <= ST_OK;
    end else if (tick_en) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      low_length       <= low_length_next;
      bit_index        <= bit_index_next;
      frame_bits       <= frame_bits_next;
      last_humidity    <= last_humidity_next;
      last_temperature <= last_temperature_next;
      last_status      <= last_status_next;
    end
  end

endmodule

@@ hdl/swhsr_out_buf.sv @@
// ----------------------------------------------------------------------------
// swhsr_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module swhsr_out_buf import swhsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;
  logic take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ hdl/single_wire_humidity_sensor_reader.sv @@
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Host side of a single-wire humidity and temperature sensor. One line
// sample per tick; one result per sample.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  start_req, line_level
//   out      out_valid / out_stall drive_low, busy_res, done_res, status,
//                                  humidity_tenths, temperature_tenths
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample is accepted every cycle while in_stall is low; its result goes
// to the output or skid entry. The sequencer update is one combinational
// pass. in_stall rises only when both result entries are full, so one
// result may wait downstream without stopping the input. Reset is
// synchronous and restores the register defaults and an idle sequencer.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader import swhsr_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_W_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     start_req,
  input  logic                     line_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     drive_low,
  output logic                     busy_res,
  output logic                     done_res,
  output logic [STATUS_W-1:0]      status,
  output logic [DATA_W-1:0]        humidity_tenths,
  output logic signed [DATA_W-1:0] temperature_tenths,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  logic in_fire;
  logic buf_full;
  res_t step_res;
  res_t out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_fire   = in_valid && !buf_full;

  swhsr_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .tick_en   (in_fire),
    .start_req (start_req),
    .line_level(line_level),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (step_res)
  );

  swhsr_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (in_fire),
    .push_data(step_res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign drive_low          = out_res.drive_low;
  assign busy_res           = out_res.busy_res;
  assign done_res           = out_res.done_res;
  assign status             = out_res.status;
  assign humidity_tenths    = out_res.humidity_tenths;
  assign temperature_tenths = out_res.temperature_tenths;

  // The skid entry is only occupied behind a held output entry.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("skid entry full while output register empty");

  // A finished reading leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !drive_low))
    else $error("done reported while still busy");

  // The line is only pulled low as part of a reading.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_low) |-> busy_res)
    else $error("line driven low while idle");

  // Status never carries an unused code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_TIMEOUT || status == ST_CHECKSUM))
    else $error("undefined status code");

endmodule
